FILE: hw/rtl/veob_pkg.sv
// ----------------------------------------------------------------------------
// veob_pkg
// Shared types and constants of the vertex edge opacity blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package veob_pkg;

  localparam int unsigned Q15_W      = 16;
  localparam logic [15:0] ONE_Q15    = 16'd32768;

  // Magnitudes at or above ten (Q8.8) saturate the edge factor at once
  localparam int unsigned FAR_MAG    = 2560;
  localparam int unsigned MAG_BITS   = 12;
  localparam int unsigned SQ_W       = 23;
  localparam int unsigned SUM_W      = 25;
  localparam logic [24:0] TEN_SQ_Q16 = 25'd6553600;

  // Square root of the squared distance scaled to Q.30
  localparam int unsigned FRAC_SHIFT = 14;
  localparam int unsigned ROOT_W     = 19;
  localparam int unsigned RAD_W      = 2 * ROOT_W;
  localparam int unsigned REM_W      = ROOT_W + 2;

  // floor(d / 10) and floor(x / 5) by reciprocal multiplication
  localparam logic [18:0] RECIP10    = 19'd419431;
  localparam int unsigned DIV10_SH   = 22;
  localparam logic [17:0] RECIP5     = 18'd209716;
  localparam int unsigned DIV5_SH    = 20;
  localparam int unsigned EOP_IN_W   = 18;

  localparam int unsigned OUT_W      = 3 * Q15_W;

  // Register index decode
  localparam logic REG_PRESENCE = 1'b0;

  typedef struct packed {
    logic        sat;
    logic [15:0] alpha;
  } veob_side_t;

endpackage

`default_nettype wire

FILE: hw/rtl/veob_sqrt.sv
// ----------------------------------------------------------------------------
// veob_sqrt
// Pipelined restoring square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module veob_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [veob_pkg::RAD_W-1:0] rad_i,
  input  wire veob_pkg::veob_side_t       side_i,
  output logic                            valid_o,
  output logic [veob_pkg::ROOT_W-1:0]     root_o,
  output veob_pkg::veob_side_t            side_o
);

  import veob_pkg::*;

  logic [RAD_W-1:0]  rad_s  [ROOT_W+1];
  logic [REM_W-1:0]  rem_s  [ROOT_W+1];
  logic [ROOT_W-1:0] root_s [ROOT_W+1];
  veob_side_t        side_s [ROOT_W+1];
  logic [ROOT_W:0]   valid_s;

  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  veob_side_t        side_q [ROOT_W];
  logic [ROOT_W-1:0] valid_q;

  assign rad_s[0]   = rad_i;
  assign rem_s[0]   = '0;
  assign root_s[0]  = '0;
  assign side_s[0]  = side_i;
  assign valid_s[0] = valid_i;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             fits;

    assign cur   = {rem_s[k], rad_s[k][RAD_W-1 -: 2]};
    assign trial = {2'b00, root_s[k], 2'b01};
    assign diff  = cur - trial;
    assign fits  = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_s[k] << 2;
        rem_q[k]  <= fits ? diff[REM_W-1:0] : cur[REM_W-1:0];
        root_q[k] <= {root_s[k][ROOT_W-2:0], fits};
        side_q[k] <= side_s[k];
      end
    end

    assign rad_s[k+1]   = rad_q[k];
    assign rem_s[k+1]   = rem_q[k];
    assign root_s[k+1]  = root_q[k];
    assign side_s[k+1]  = side_q[k];
    assign valid_s[k+1] = valid_q[k];
  end

  assign valid_o = valid_s[ROOT_W];
  assign root_o  = root_s[ROOT_W];
  assign side_o  = side_s[ROOT_W];

endmodule

`default_nettype wire

FILE: hw/rtl/vertex_edge_opacity_blend.sv
// ----------------------------------------------------------------------------
// vertex_edge_opacity_blend
// Per-vertex edge factor, blended opacity and averaged alpha.
//
// Channel   Dir  Handshake          Content
// s_*       in   tvalid/tready      offset_x, offset_y, offset_z, vertex_alpha
// m_*       out  tvalid/tready      edge_amount, opacity, blended_alpha
// apb       in   psel/penable/pwr   presence opacity at byte address 0
//
// One vertex enters per cycle while s_tready is high; the result reaches the output
// register through 3 stages before and 5 stages after the 19 root-bit stages of
// the square root. The whole pipeline advances together and holds only while both
// output register and skid register are full.
// Reset clears all valid bits and the presence opacity register.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_edge_opacity_blend #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       s_tvalid,
  output logic                                            s_tready,
  // offset_x, offset_y, offset_z, vertex_alpha[15:0], zero pad
  input  wire logic [((3*COORD_WIDTH+16+7)/8)*8-1:0]      s_tdata,
  output logic                                            m_tvalid,
  input  wire logic                                       m_tready,
  // edge_amount[15:0], opacity[15:0], blended_alpha[15:0]
  output logic [veob_pkg::OUT_W-1:0]                      m_tdata,
  input  wire logic                                       psel,
  input  wire logic                                       penable,
  input  wire logic                                       pwrite,
  input  wire logic [2:0]                                 paddr,
  input  wire logic [31:0]                                pwdata,
  output logic [31:0]                                     prdata,
  output logic                                            pready
);

  import veob_pkg::*;

  localparam int unsigned MAG_W = (COORD_WIDTH > 12) ? COORD_WIDTH : 13;

  // Configuration
  logic [15:0] base_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_PRESENCE);
  assign prdata = (paddr[2] == REG_PRESENCE) ? {16'd0, base_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_wr) begin
      base_q <= pwdata[15:0];
    end
  end

  // Pipeline control
  logic en;
  logic out_valid_q, skid_valid_q;
  logic [OUT_W-1:0] out_q, skid_q;

  assign en       = !skid_valid_q;
  assign s_tready = !skid_valid_q;

  // Stage 1: magnitudes
  logic [MAG_BITS-1:0] mag_c [3];
  logic [2:0]          far_c;
  logic                v1_q;
  logic [MAG_BITS-1:0] mag_q [3];
  logic                far1_q;
  logic [15:0]         alpha1_q;

  for (genvar c = 0; c < 3; c++) begin : g_mag
    logic [COORD_WIDTH-1:0] raw;
    logic [COORD_WIDTH-1:0] absv;
    logic [MAG_W-1:0]       wide;

    assign raw      = s_tdata[c*COORD_WIDTH +: COORD_WIDTH];
    assign absv     = raw[COORD_WIDTH-1] ? (~raw + 1'b1) : raw;
    assign wide     = MAG_W'(absv);
    assign far_c[c] = wide >= MAG_W'(FAR_MAG);
    assign mag_c[c] = wide[MAG_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q    <= mag_c;
      far1_q   <= |far_c;
      alpha1_q <= s_tdata[3*COORD_WIDTH +: 16];
    end
  end

  // Stage 2: squares
  logic [2*MAG_BITS-1:0] sq_c [3];
  logic [SQ_W-1:0]       sq_q [3];
  logic                  v2_q, far2_q;
  logic [15:0]           alpha2_q;

  for (genvar c = 0; c < 3; c++) begin : g_sq
    assign sq_c[c] = mag_q[c] * mag_q[c];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= sq_c[i][SQ_W-1:0];
      end
      far2_q   <= far1_q;
      alpha2_q <= alpha1_q;
    end
  end

  // Stage 3: sum of squares, range check, radicand
  logic [SUM_W-1:0] sum_c;
  logic             v3_q;
  logic [RAD_W-1:0] rad_q;
  veob_side_t       side3_q;

  assign sum_c = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q         <= RAD_W'({sum_c[SQ_W-1:0], {FRAC_SHIFT{1'b0}}});
      side3_q.sat   <= far2_q || (sum_c >= TEN_SQ_Q16);
      side3_q.alpha <= alpha2_q;
    end
  end

  // Square root
  logic              vr;
  logic [ROOT_W-1:0] root;
  veob_side_t        side_r;

  veob_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (rad_q),
    .side_i  (side3_q),
    .valid_o (vr),
    .root_o  (root),
    .side_o  (side_r)
  );

  // Stage 4: distance times one tenth
  logic [2*ROOT_W-1:0] p10_c;
  logic [2*ROOT_W-1:0] p10_q;
  logic                v4_q, sat4_q;
  logic [15:0]         alpha4_q;

  assign p10_c = root * RECIP10;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p10_q    <= p10_c;
      sat4_q   <= side_r.sat;
      alpha4_q <= side_r.alpha;
    end
  end

  // Stage 5: edge factor
  logic        v5_q;
  logic [15:0] e5_q, alpha5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e5_q     <= sat4_q ? ONE_Q15 : p10_q[DIV10_SH +: 16];
      alpha5_q <= alpha4_q;
    end
  end

  // Stage 6: (4e + 1) / 5 by reciprocal
  logic [EOP_IN_W-1:0]   x5_c;
  logic [2*EOP_IN_W-1:0] p5_c, p5_q;
  logic                  v6_q;
  logic [15:0]           e6_q, alpha6_q;

  assign x5_c = {e5_q, 2'b00} + EOP_IN_W'(ONE_Q15);
  assign p5_c = x5_c * RECIP5;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_q     <= p5_c;
      e6_q     <= e5_q;
      alpha6_q <= alpha5_q;
    end
  end

  // Stage 7: blend products
  logic [15:0] eop_c, inv_c;
  logic [31:0] pb_c, pe_c, pb_q, pe_q;
  logic        v7_q;
  logic [15:0] e7_q, alpha7_q;

  assign eop_c = p5_q[DIV5_SH +: 16];
  assign inv_c = ONE_Q15 - e6_q;
  assign pb_c  = inv_c * base_q;
  assign pe_c  = e6_q * eop_c;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pb_q     <= pb_c;
      pe_q     <= pe_c;
      e7_q     <= e6_q;
      alpha7_q <= alpha6_q;
    end
  end

  // Stage 8: opacity
  logic [32:0] osum_c;
  logic [17:0] ow_c;
  logic        v8_q;
  logic [15:0] e8_q, op8_q, alpha8_q;

  assign osum_c = {1'b0, pb_q} + {1'b0, pe_q};
  assign ow_c   = osum_c[32:15];

  always_ff @(posedge clk_i) begin
    if (en) begin
      op8_q    <= (ow_c > 18'(ONE_Q15)) ? ONE_Q15 : ow_c[15:0];
      e8_q     <= e7_q;
      alpha8_q <= alpha7_q;
    end
  end

  // Blended alpha into the output register
  logic [16:0]      bsum_c;
  logic [15:0]      bl_c;
  logic [OUT_W-1:0] res_c;
  logic             push, pop;

  assign bsum_c = {1'b0, alpha8_q} + {1'b0, op8_q};
  assign bl_c   = (bsum_c[16:1] > ONE_Q15) ? ONE_Q15 : bsum_c[16:1];
  assign res_c  = {bl_c, op8_q, e8_q};
  assign push   = en && v8_q;
  assign pop    = out_valid_q && m_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= vr;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res_c;
      end else begin
        out_q <= res_c;
      end
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_q;

`ifndef ASSERT_OFF
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  a_result_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tdata[15:0] <= ONE_Q15) && (m_tdata[31:16] <= ONE_Q15)
                 && (m_tdata[47:32] <= ONE_Q15))
    else $error("result field above one");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable({v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q}))
    else $error("pipeline valid bits moved during stall");
`endif

endmodule

`default_nettype wire
